// ===== design/wav_header_parser_assert.svh =====
// assertion macros for the wav header parser
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WAVHP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wavhp assertion failed");
// next-cycle implication
`define WAVHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wavhp assertion failed");
`else
`define WAVHP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define WAVHP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/wavhp_pkg.sv =====
// types and constants shared by the wav header parser
package wavhp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_FMT_HDR,
    PH_FMT_SKIP,
    PH_FMT_BODY,
    PH_FMT_REST,
    PH_DATA_HDR,
    PH_DATA_SKIP,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_RIFF,
    ST_NOT_WAVE,
    ST_NO_FMT,
    ST_NOT_PCM,
    ST_NO_DATA,
    ST_TRUNCATED,
    ST_BAD_SIZE
  } status_t;

  localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
  localparam logic [15:0] PCM_CODE     = 16'h0001;
  localparam logic [30:0] FMT_MIN_SIZE = 31'd16;

  typedef struct packed {
    status_t     status;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [30:0] sample_freq;
    logic [31:0] data_offset;
    logic [30:0] data_length;
  } result_t;

endpackage

// ===== design/wavhp_parser.sv =====
// per-byte parser state and result formation
`include "wav_header_parser_assert.svh"

module wavhp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        byte_value,
  input  logic              is_final,
  output wavhp_pkg::result_t res
);
  import wavhp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] file_position, pos_next;
  logic [3:0]  field_byte_index, idx_next;
  logic [31:0] id_shift, id_next;
  logic [31:0] size_shift, size_next;
  logic [30:0] skip_remaining, skip_next;
  logic [15:0] format_code, format_next;
  logic [15:0] channels_held, channels_next;
  logic [15:0] bits_held, bits_next;
  logic [30:0] rate_held, rate_next;
  logic [31:0] offset_held, offset_next;
  logic [30:0] length_held, length_next;
  logic [31:0] payload_count, count_next;
  status_t     error_code, error_next;
  status_t     st;

  logic [31:0] pos_inc;
  logic [31:0] id_in;
  logic [31:0] size_in;
  logic        restarted;

  assign pos_inc = file_position + 32'd1;
  assign id_in   = {byte_value, id_shift[31:8]};
  assign size_in = {byte_value, size_shift[31:8]};

  always_comb begin
    phase_next    = phase;
    pos_next      = file_position;
    idx_next      = field_byte_index;
    id_next       = id_shift;
    size_next     = size_shift;
    skip_next     = skip_remaining;
    format_next   = format_code;
    channels_next = channels_held;
    bits_next     = bits_held;
    rate_next     = rate_held;
    offset_next   = offset_held;
    length_next   = length_held;
    count_next    = payload_count;
    error_next    = error_code;
    st            = ST_OK;
    res           = '0;
    if (fire) begin
      pos_next = pos_inc;
      unique case (phase) inside
        PH_RIFF: begin
          id_next = id_in;
          if (field_byte_index == 4'd3 && id_in != TAG_RIFF) begin
            error_next = ST_NOT_RIFF;
            phase_next = PH_ERROR;
          end else if (field_byte_index == 4'd11) begin
            if (id_in != TAG_WAVE) begin
              error_next = ST_NOT_WAVE;
              phase_next = PH_ERROR;
            end else begin
              phase_next = PH_FMT_HDR;
              idx_next   = 4'd0;
            end
          end else begin
            idx_next = field_byte_index + 4'd1;
          end
        end
        PH_FMT_HDR, PH_DATA_HDR: begin
          if (field_byte_index < 4'd4) begin
            id_next = id_in;
          end else begin
            size_next = size_in;
          end
          if (field_byte_index != 4'd7) begin
            idx_next = field_byte_index + 4'd1;
          end else begin
            idx_next = 4'd0;
            if (size_in[31]) begin
              error_next = ST_BAD_SIZE;
              phase_next = PH_ERROR;
            end else if (phase == PH_FMT_HDR && id_shift == TAG_FMT) begin
              if (size_in[30:0] < FMT_MIN_SIZE) begin
                error_next = ST_BAD_SIZE;
                phase_next = PH_ERROR;
              end else begin
                skip_next  = size_in[30:0] - FMT_MIN_SIZE;
                phase_next = PH_FMT_BODY;
              end
            end else if (phase == PH_DATA_HDR && id_shift == TAG_DATA) begin
              offset_next = pos_inc;
              length_next = size_in[30:0];
              count_next  = 32'd0;
              phase_next  = PH_PAYLOAD;
            end else if (size_in[30:0] != 31'd0) begin
              skip_next  = size_in[30:0];
              phase_next = (phase == PH_FMT_HDR) ? PH_FMT_SKIP : PH_DATA_SKIP;
            end
          end
        end
        PH_FMT_BODY: begin
          case (field_byte_index)
            4'd0:    format_next[7:0]    = byte_value;
            4'd1:    format_next[15:8]   = byte_value;
            4'd2:    channels_next[7:0]  = byte_value;
            4'd3:    channels_next[15:8] = byte_value;
            4'd4:    rate_next[7:0]      = byte_value;
            4'd5:    rate_next[15:8]     = byte_value;
            4'd6:    rate_next[23:16]    = byte_value;
            4'd7:    rate_next[30:24]    = byte_value[6:0];
            4'd14:   bits_next[7:0]      = byte_value;
            4'd15:   bits_next[15:8]     = byte_value;
            default: ;
          endcase
          if (field_byte_index == 4'd15) begin
            idx_next = 4'd0;
            if (format_code != PCM_CODE) begin
              error_next = ST_NOT_PCM;
              phase_next = PH_ERROR;
            end else begin
              phase_next = (skip_remaining != 31'd0) ? PH_FMT_REST : PH_DATA_HDR;
            end
          end else begin
            idx_next = field_byte_index + 4'd1;
          end
        end
        PH_FMT_SKIP, PH_FMT_REST, PH_DATA_SKIP: begin
          skip_next = skip_remaining - 31'd1;
          if (skip_remaining == 31'd1) begin
            phase_next = (phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
          end
        end
        PH_PAYLOAD: begin
          if (payload_count != 32'hFFFF_FFFF) begin
            count_next = payload_count + 32'd1;
          end
        end
        default: ;
      endcase

      if (is_final) begin
        unique case (phase_next) inside
          PH_RIFF:
            st = (idx_next < 4'd4) ? ST_NOT_RIFF : ST_NOT_WAVE;
          PH_FMT_HDR, PH_FMT_SKIP:
            st = ST_NO_FMT;
          PH_FMT_BODY:
            st = ST_TRUNCATED;
          PH_FMT_REST, PH_DATA_HDR, PH_DATA_SKIP:
            st = ST_NO_DATA;
          PH_PAYLOAD:
            st = (count_next >= {1'b0, length_next}) ? ST_OK : ST_TRUNCATED;
          default:
            st = error_next;
        endcase
        res.status = st;
        if (st == ST_OK) begin
          res.channel_count = channels_next;
          res.sample_bits   = bits_next;
          res.sample_freq   = rate_next;
          res.data_offset   = offset_next;
          res.data_length   = length_next;
        end
        // ready for the next file
        phase_next = PH_RIFF;
        pos_next   = 32'd0;
        idx_next   = 4'd0;
        count_next = 32'd0;
        error_next = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RIFF;
      file_position    <= 32'd0;
      field_byte_index <= 4'd0;
      payload_count    <= 32'd0;
      error_code       <= ST_OK;
    end else begin
      phase            <= phase_next;
      file_position    <= pos_next;
      field_byte_index <= idx_next;
      payload_count    <= count_next;
      error_code       <= error_next;
    end
  end

  always_ff @(posedge clk) begin
    id_shift       <= id_next;
    size_shift     <= size_next;
    skip_remaining <= skip_next;
    format_code    <= format_next;
    channels_held  <= channels_next;
    bits_held      <= bits_next;
    rate_held      <= rate_next;
    offset_held    <= offset_next;
    length_held    <= length_next;
  end

  assign restarted = phase == PH_RIFF && file_position == 32'd0 && error_code == ST_OK;

  `WAVHP_ASSERT_IMPLY(a_error_has_code, clk, rst, phase == PH_ERROR, error_code != ST_OK)
  `WAVHP_ASSERT_NEXT(a_final_restarts, clk, rst, fire && is_final, restarted)

endmodule

// ===== design/wav_header_parser.sv =====
// wav header parser top level: input register, parser and result register
// a final byte passes from the input register through the parser, and its result is registered in the result register
// throughput: one byte per cycle while no result waits in the result register
// a result appears only for a byte flagged final, after which parsing restarts
// rst (synchronous) clears the handshake registers and parser control state
`include "wav_header_parser_assert.svh"

module wav_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] channel_count,
  output logic [15:0] sample_bits,
  output logic [30:0] sample_freq,
  output logic [31:0] data_offset,
  output logic [30:0] data_length
);
  import wavhp_pkg::*;

  logic       in_q_valid;
  logic [7:0] byte_q;
  logic       final_q;
  logic       can_fire;
  logic       fire;
  logic       take_in;
  logic       fields_clear;
  result_t    step_res;
  result_t    out_res;

  assign can_fire = !out_valid || !out_stall;
  assign fire     = in_q_valid && can_fire;
  assign in_stall = in_q_valid && !can_fire;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      in_q_valid <= take_in || (in_q_valid && !fire);
      out_valid  <= (fire && final_q) || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      byte_q  <= byte_value;
      final_q <= is_final;
    end
    if (fire && final_q) begin
      out_res <= step_res;
    end
  end

  wavhp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .byte_value (byte_q),
    .is_final   (final_q),
    .res        (step_res)
  );

  assign status        = out_res.status;
  assign channel_count = out_res.channel_count;
  assign sample_bits   = out_res.sample_bits;
  assign sample_freq   = out_res.sample_freq;
  assign data_offset   = out_res.data_offset;
  assign data_length   = out_res.data_length;

  assign fields_clear = out_res.channel_count == 16'd0 && out_res.sample_bits == 16'd0 &&
                        out_res.sample_freq == 31'd0 && out_res.data_offset == 32'd0 &&
                        out_res.data_length == 31'd0;

  `WAVHP_ASSERT_IMPLY(a_result_from_final, clk, rst, out_valid && !$past(out_valid), $past(fire && final_q))
  `WAVHP_ASSERT_IMPLY(a_error_fields_clear, clk, rst, out_valid && out_res.status != ST_OK, fields_clear)

endmodule
